FILE: rtl/fau_pkg.sv
package fau_pkg;

  // operand and result widths
  localparam int unsigned OPERAND_BITS = 16;
  localparam int unsigned NUM_BITS     = 33;
  localparam int unsigned DEN_BITS     = 32;
  localparam int unsigned PROD_BITS    = 2 * OPERAND_BITS;
  localparam int unsigned CNT_BITS     = $clog2(OPERAND_BITS);
  localparam int unsigned SHIFT_BITS   = $clog2(OPERAND_BITS);

  // operation codes
  localparam logic [2:0] OP_MAKE = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_EQ   = 3'd3;
  localparam logic [2:0] OP_NE   = 3'd4;

  typedef struct packed {
    logic [2:0]              opcode;
    logic [OPERAND_BITS-1:0] left_num;
    logic [OPERAND_BITS-1:0] left_den;
    logic [OPERAND_BITS-1:0] right_num;
    logic [OPERAND_BITS-1:0] right_den;
  } in_word_t;

  typedef struct packed {
    logic [NUM_BITS-1:0] result_num;
    logic [DEN_BITS-1:0] result_den;
    logic                result_empty;
    logic                compare_true;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_GCD,
    ST_DIV,
    ST_QUO,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_DEN,
    ST_DONE
  } state_e;

  // multiplier operand pairs
  typedef enum logic [1:0] {
    SEL_LR,
    SEL_LN,
    SEL_DN,
    SEL_DD
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     gcd_step;
    logic     div_init;
    logic     div_step;
    logic     quo_wr;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_en;
    logic     den_wr;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       left_ok;
    logic       gcd_eq;
  } ctrl_stat_t;

endpackage

FILE: rtl/fau_datapath.sv
module fau_datapath (
  input  logic               clk_i,
  input  fau_pkg::in_word_t   in_word_i,
  input  fau_pkg::ctrl_cmd_t  cmd_i,
  output fau_pkg::ctrl_stat_t stat_o,
  output fau_pkg::out_word_t  result_o
);

  localparam int unsigned OB = fau_pkg::OPERAND_BITS;

  // captured operands
  logic [2:0]    op_q;
  logic [OB-1:0] ln_q, ld_q, rn_q, rd_q;

  // gcd registers
  logic [OB-1:0]                   a_q, a_d, b_q, b_d;
  logic [fau_pkg::SHIFT_BITS-1:0]  k_q, k_d;
  logic                            a_even, b_even, a_gt;
  logic [OB-1:0]                   diff;

  // divider registers, one lane per part
  logic [OB-1:0] g_q;
  logic [OB-1:0] rem_n_q, rem_d_q, quo_n_q, quo_d_q;
  logic [OB:0]   trial_n, trial_d, sub_n, sub_d;
  logic          ge_n, ge_d;

  // multiplier and result registers
  logic [OB-1:0]                  mul_a, mul_b;
  logic [fau_pkg::PROD_BITS-1:0]  prod_q;
  logic [fau_pkg::NUM_BITS-1:0]   num_q;
  logic [fau_pkg::DEN_BITS-1:0]   den_q;
  logic                           cmp_q, cmp_d;
  logic                           left_ok, parts_eq, arith_op;

  // operand capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= in_word_i.opcode;
      ln_q <= in_word_i.left_num;
      ld_q <= in_word_i.left_den;
      rn_q <= in_word_i.right_num;
      rd_q <= in_word_i.right_den;
    end
  end

  // binary gcd step: strip common twos, then halve or subtract
  assign a_even = ~a_q[0];
  assign b_even = ~b_q[0];
  assign a_gt   = a_q > b_q;
  assign diff   = a_gt ? (a_q - b_q) : (b_q - a_q);

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (cmd_i.load) begin
      a_d = in_word_i.left_num;
      b_d = in_word_i.left_den;
      k_d = '0;
    end else if (cmd_i.gcd_step) begin
      if (a_even && b_even) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + 1'b1;
      end else if (a_even) begin
        a_d = a_q >> 1;
      end else if (b_even) begin
        b_d = b_q >> 1;
      end else if (a_gt) begin
        a_d = diff >> 1;
      end else begin
        b_d = diff >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
  end

  // restoring division of both parts by the gcd, one bit per cycle
  assign trial_n = {rem_n_q, quo_n_q[OB-1]};
  assign trial_d = {rem_d_q, quo_d_q[OB-1]};
  assign sub_n   = trial_n - {1'b0, g_q};
  assign sub_d   = trial_d - {1'b0, g_q};
  assign ge_n    = trial_n >= {1'b0, g_q};
  assign ge_d    = trial_d >= {1'b0, g_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      g_q     <= a_q << k_q;
      rem_n_q <= '0;
      rem_d_q <= '0;
      quo_n_q <= ln_q;
      quo_d_q <= ld_q;
    end else if (cmd_i.div_step) begin
      rem_n_q <= ge_n ? sub_n[OB-1:0] : trial_n[OB-1:0];
      rem_d_q <= ge_d ? sub_d[OB-1:0] : trial_d[OB-1:0];
      quo_n_q <= {quo_n_q[OB-2:0], ge_n};
      quo_d_q <= {quo_d_q[OB-2:0], ge_d};
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      fau_pkg::SEL_LR: begin
        mul_a = ln_q;
        mul_b = rd_q;
      end
      fau_pkg::SEL_LN: begin
        mul_a = ln_q;
        mul_b = rn_q;
      end
      fau_pkg::SEL_DN: begin
        mul_a = ld_q;
        mul_b = rn_q;
      end
      fau_pkg::SEL_DD: begin
        mul_a = ld_q;
        mul_b = rd_q;
      end
      default: begin
        mul_a = ld_q;
        mul_b = rd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= fau_pkg::PROD_BITS'(mul_a) * fau_pkg::PROD_BITS'(mul_b);
    end
  end

  // compare outcome
  assign left_ok  = (ln_q != '0) && (ld_q != '0);
  assign parts_eq = (ln_q == rn_q) && (ld_q == rd_q);

  always_comb begin
    case (op_q)
      fau_pkg::OP_EQ: cmp_d = left_ok && parts_eq;
      fau_pkg::OP_NE: cmp_d = left_ok && !parts_eq;
      default:        cmp_d = 1'b0;
    endcase
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      num_q <= '0;
      den_q <= '0;
      cmp_q <= cmp_d;
    end else begin
      if (cmd_i.quo_wr) begin
        num_q <= fau_pkg::NUM_BITS'(quo_n_q);
        den_q <= fau_pkg::DEN_BITS'(quo_d_q);
      end
      if (cmd_i.acc_en) begin
        num_q <= num_q + fau_pkg::NUM_BITS'(prod_q);
      end
      if (cmd_i.den_wr) begin
        den_q <= fau_pkg::DEN_BITS'(prod_q);
      end
    end
  end

  // status and result word
  assign arith_op = (op_q == fau_pkg::OP_MAKE) || (op_q == fau_pkg::OP_ADD) ||
                    (op_q == fau_pkg::OP_MUL);

  assign stat_o.opcode  = op_q;
  assign stat_o.left_ok = left_ok;
  assign stat_o.gcd_eq  = a_q == b_q;

  assign result_o.result_num   = num_q;
  assign result_o.result_den   = den_q;
  assign result_o.result_empty = arith_op && (num_q == '0) && (den_q == '0);
  assign result_o.compare_true = cmp_q;

endmodule

FILE: rtl/fau_ctrl.sv
module fau_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_free_i,
  input  fau_pkg::ctrl_stat_t stat_i,
  output logic                in_ready_o,
  output fau_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [fau_pkg::CNT_BITS-1:0] LastBit =
    fau_pkg::CNT_BITS'(fau_pkg::OPERAND_BITS - 1);

  fau_pkg::state_e state_q, state_d;
  logic [fau_pkg::CNT_BITS-1:0] cnt_q, cnt_d;
  logic is_add;

  assign is_add = stat_i.opcode == fau_pkg::OP_ADD;

  // state and bit counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fau_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      fau_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = fau_pkg::ST_DECODE;
      end
      fau_pkg::ST_DECODE: begin
        if (stat_i.left_ok && stat_i.opcode == fau_pkg::OP_MAKE) begin
          state_d = fau_pkg::ST_GCD;
        end else if (stat_i.left_ok &&
                     (is_add || stat_i.opcode == fau_pkg::OP_MUL)) begin
          state_d = fau_pkg::ST_MUL_A;
        end else begin
          state_d = fau_pkg::ST_DONE;
        end
      end
      fau_pkg::ST_GCD: begin
        if (stat_i.gcd_eq) begin
          state_d = fau_pkg::ST_DIV;
          cnt_d   = '0;
        end
      end
      fau_pkg::ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastBit) state_d = fau_pkg::ST_QUO;
      end
      fau_pkg::ST_QUO:   state_d = fau_pkg::ST_DONE;
      fau_pkg::ST_MUL_A: state_d = is_add ? fau_pkg::ST_MUL_B : fau_pkg::ST_MUL_C;
      fau_pkg::ST_MUL_B: state_d = fau_pkg::ST_MUL_C;
      fau_pkg::ST_MUL_C: state_d = fau_pkg::ST_DEN;
      fau_pkg::ST_DEN:   state_d = fau_pkg::ST_DONE;
      fau_pkg::ST_DONE: begin
        if (out_free_i) state_d = fau_pkg::ST_IDLE;
      end
      default: state_d = fau_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.mul_sel = fau_pkg::SEL_DD;
    in_ready_o = 1'b0;
    case (state_q)
      fau_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      fau_pkg::ST_DECODE: cmd_o.clear = 1'b1;
      fau_pkg::ST_GCD: begin
        cmd_o.gcd_step = !stat_i.gcd_eq;
        cmd_o.div_init = stat_i.gcd_eq;
      end
      fau_pkg::ST_DIV: cmd_o.div_step = 1'b1;
      fau_pkg::ST_QUO: cmd_o.quo_wr = 1'b1;
      fau_pkg::ST_MUL_A: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = is_add ? fau_pkg::SEL_LR : fau_pkg::SEL_LN;
      end
      fau_pkg::ST_MUL_B: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = fau_pkg::SEL_DN;
        cmd_o.acc_en  = 1'b1;
      end
      fau_pkg::ST_MUL_C: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = fau_pkg::SEL_DD;
        cmd_o.acc_en  = 1'b1;
      end
      fau_pkg::ST_DEN:  cmd_o.den_wr = 1'b1;
      fau_pkg::ST_DONE: cmd_o.out_load = out_free_i;
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: rtl/fraction_arithmetic_unit.sv
// One word at a time, accept to next accept: the result word becomes valid as the
//   block returns to idle, where it can take the next word.
// Make: decode, gcd steps, divide steps, quotient write, done. Add: decode,
//   multiply A, B and C, denominator, done. Multiply skips B. Others: decode, done.
// The output register holds a finished result while the next word is taken.
// Reset (rst_ni low, asynchronous) returns to idle with no result pending.
module fraction_arithmetic_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fau_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fau_pkg::out_word_t out_word_o
);

  fau_pkg::ctrl_cmd_t  cmd;
  fau_pkg::ctrl_stat_t stat;
  fau_pkg::out_word_t  result;
  logic                in_ready;
  logic                out_free;
  logic                out_valid_q, out_valid_d;
  fau_pkg::out_word_t  out_word_q;

  assign in_stall_o = !in_ready;
  assign out_free   = !out_valid_q || !out_stall_i;

  fau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  fau_datapath u_datapath (
    .clk_i     (clk_i),
    .in_word_i (in_word_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .result_o  (result)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: test/fraction_arithmetic_unit_tb.sv
module fraction_arithmetic_unit_tb;
  import fau_pkg::*;

  // opcodes with no operation behind them
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  localparam int unsigned RANDOM_WORDS = 1350;
  localparam int unsigned PHASES       = 3;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned MAX_REPORTS  = 10;

  // fraction results waiting for the block, checked in order
  class fraction_scoreboard;
    out_word_t fraction_q[$];
    int        failures;

    // expected result of one operation on two fractions
    function out_word_t compute_fraction(in_word_t w);
      out_word_t   r;
      logic [63:0] ln, ld, rn, rd, a, b, t, num, den;
      bit          left_ok;
      r       = '0;
      ln      = 64'(w.left_num);
      ld      = 64'(w.left_den);
      rn      = 64'(w.right_num);
      rd      = 64'(w.right_den);
      left_ok = (ln != 0) && (ld != 0);
      num     = 0;
      den     = 0;
      case (w.opcode)
        OP_MAKE: begin
          if (left_ok) begin
            a = ln;
            b = ld;
            while (b != 0) begin
              t = a % b;
              a = b;
              b = t;
            end
            num = ln / a;
            den = ld / a;
          end
        end
        OP_ADD: begin
          if (left_ok) begin
            num = ln * rd + ld * rn;
            den = ld * rd;
          end
        end
        OP_MUL: begin
          if (left_ok) begin
            num = ln * rn;
            den = ld * rd;
          end
        end
        OP_EQ: r.compare_true = left_ok && (ln == rn) && (ld == rd);
        OP_NE: r.compare_true = left_ok && ((ln != rn) || (ld != rd));
        default: ;
      endcase
      r.result_num = num[NUM_BITS-1:0];
      r.result_den = den[DEN_BITS-1:0];
      if (w.opcode <= OP_MUL)
        r.result_empty = (r.result_num == '0) && (r.result_den == '0);
      return r;
    endfunction

    function void note_input(in_word_t w);
      fraction_q.push_back(compute_fraction(w));
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp;
      if (fraction_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result num=%0d den=%0d empty=%0b cmp=%0b",
                   got.result_num, got.result_den, got.result_empty, got.compare_true);
        return;
      end
      exp = fraction_q.pop_front();
      if (got.result_num !== exp.result_num || got.result_den !== exp.result_den ||
          got.result_empty !== exp.result_empty || got.compare_true !== exp.compare_true)
      begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("mismatch: exp num=%0d den=%0d empty=%0b cmp=%0b, got num=%0d den=%0d empty=%0b cmp=%0b",
                   exp.result_num, exp.result_den, exp.result_empty, exp.compare_true,
                   got.result_num, got.result_den, got.result_empty, got.compare_true);
      end
    endfunction

    function int pending();
      return fraction_q.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  fraction_scoreboard board;
  int unsigned        send_idle_pct;
  int unsigned        recv_stall_pct;
  int unsigned        quiet_cycles;

  fraction_arithmetic_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic in_word_t pack_word(logic [2:0] op, int unsigned ln, int unsigned ld,
                                         int unsigned rn, int unsigned rd);
    in_word_t w;
    w.opcode    = op;
    w.left_num  = ln[OPERAND_BITS-1:0];
    w.left_den  = ld[OPERAND_BITS-1:0];
    w.right_num = rn[OPERAND_BITS-1:0];
    w.right_den = rd[OPERAND_BITS-1:0];
    return w;
  endfunction

  // operand part biased toward zero, all ones and small values
  function automatic int unsigned pick_part();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 8)  return 0;
    if (sel < 16) return 65535;
    if (sel < 45) return $urandom_range(20, 1);
    return $urandom_range(65535);
  endfunction

  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned g, sel;
    w = pack_word($urandom_range(99) < 8 ? 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST))
                                         : 3'($urandom_range(OP_NE, OP_MAKE)),
                  pick_part(), pick_part(), pick_part(), pick_part());
    sel = $urandom_range(99);
    // make: parts sharing a common factor
    if (w.opcode == OP_MAKE && sel < 40) begin
      g = $urandom_range(255, 1);
      w.left_num = OPERAND_BITS'(g * $urandom_range(255, 1));
      w.left_den = OPERAND_BITS'(g * $urandom_range(255, 1));
    end
    // compares: equal fractions or one part equal
    if (w.opcode == OP_EQ || w.opcode == OP_NE) begin
      if (sel < 40) begin
        w.right_num = w.left_num;
        w.right_den = w.left_den;
      end else if (sel < 55) begin
        w.right_num = w.left_num;
      end else if (sel < 70) begin
        w.right_den = w.left_den;
      end
    end
    return w;
  endfunction

  // offer one word and wait for it to be taken
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_input(w);
  endtask

  // result side: check taken words, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(out_word_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[fraction_arithmetic_unit] ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    board          = new();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_word_i      = '0;
    out_stall_i    = 1'b0;
    quiet_cycles   = 0;
    send_idle_pct  = 27;
    recv_stall_pct = 66;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // make: empty parts, extremes, coprime and reducible pairs
    send_word(pack_word(OP_MAKE, 0, 0, 65535, 65535));
    send_word(pack_word(OP_MAKE, 0, 5, 0, 0));
    send_word(pack_word(OP_MAKE, 7, 0, 0, 0));
    send_word(pack_word(OP_MAKE, 65535, 65535, 0, 0));
    send_word(pack_word(OP_MAKE, 12, 18, 0, 0));
    send_word(pack_word(OP_MAKE, 65521, 65519, 0, 0));
    send_word(pack_word(OP_MAKE, 32768, 2, 0, 0));
    send_word(pack_word(OP_MAKE, 1, 65535, 0, 0));
    // add: widest sum, empty left, empty right
    send_word(pack_word(OP_ADD, 65535, 65535, 65535, 65535));
    send_word(pack_word(OP_ADD, 0, 3, 5, 7));
    send_word(pack_word(OP_ADD, 1, 2, 0, 0));
    send_word(pack_word(OP_ADD, 1, 2, 1, 3));
    // multiply: widest product, empty left, empty right
    send_word(pack_word(OP_MUL, 65535, 65535, 65535, 65535));
    send_word(pack_word(OP_MUL, 5, 0, 3, 4));
    send_word(pack_word(OP_MUL, 3, 4, 0, 5));
    // compares: equal, empty left, one part differing
    send_word(pack_word(OP_EQ, 3, 4, 3, 4));
    send_word(pack_word(OP_EQ, 0, 4, 0, 4));
    send_word(pack_word(OP_EQ, 3, 4, 3, 5));
    send_word(pack_word(OP_NE, 3, 4, 3, 4));
    send_word(pack_word(OP_NE, 2, 4, 3, 4));
    send_word(pack_word(OP_NE, 3, 4, 3, 5));
    send_word(pack_word(OP_NE, 0, 4, 3, 5));
    // codes with no operation
    send_word(pack_word(OP_SPARE_FIRST, 65535, 65535, 65535, 65535));
    send_word(pack_word(OP_SPARE_FIRST + 3'd1, 1, 1, 1, 1));
    send_word(pack_word(OP_SPARE_LAST, 65535, 1, 1, 65535));

    // random words: receiver mostly stalls, then sender mostly idles, then neither
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 27;
          recv_stall_pct = 66;
        end
        1: begin
          send_idle_pct  = 66;
          recv_stall_pct = 27;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int i = 0; i < RANDOM_WORDS / PHASES; i++)
        send_word(random_word());
    end
    in_valid_i <= 1'b0;

    // drain
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.failures == 0 && board.pending() == 0)
      $display("[fraction_arithmetic_unit] OK");
    else
      $display("[fraction_arithmetic_unit] ERROR");
    $finish;
  end

endmodule

FILE: fraction_arithmetic_unit.f
rtl/fau_pkg.sv
rtl/fau_datapath.sv
rtl/fau_ctrl.sv
rtl/fraction_arithmetic_unit.sv
test/fraction_arithmetic_unit_tb.sv
